// File: rtl/i2c_master_register_access_unit_macros.svh
// Assertion macros for the I2C register access unit.
`ifndef I2C_MASTER_REGISTER_ACCESS_UNIT_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define I2CRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define I2CRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define I2CRA_ASSERT_IMP(lbl, ante, cons, msg)
`define I2CRA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/i2cra_pkg.sv
// Types and constants shared by the I2C register access unit.
package i2cra_pkg;

  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 10'd6;
  localparam logic [CFG_W-1:0] SETUP_RST       = 10'd5;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP       = 2'd1;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // Byte position within a transaction
  localparam logic [2:0] STEP_DEV   = 3'd0;
  localparam logic [2:0] STEP_REG   = 3'd1;
  localparam logic [2:0] STEP_LO    = 3'd2;
  localparam logic [2:0] STEP_HI    = 3'd3;
  localparam logic [2:0] STEP_RD_HI = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_W_LOW, PH_W_SET, PH_W_HIGH,
    PH_WA_LOW, PH_WA_REL, PH_WA_HIGH, PH_R_LOW, PH_R_HIGH,
    PH_RA_LOW, PH_RA_SET, PH_RA_HIGH, PH_STOP_A, PH_STOP_B
  } phase_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [15:0] wdata;
    logic        is_word;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic        nack_error;
    logic [15:0] rdata;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic        is_read;
    logic [7:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [15:0] wdata;
    logic        is_word;
    logic        sda_in;
  } cmd_t;

  typedef struct packed {
    logic        is_read;
    logic        is_word;
    logic [7:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [15:0] wdata;
  } held_t;

endpackage

// File: rtl/i2cra_fifo.sv
// Small generic register queue.
module i2cra_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: rtl/i2cra_front.sv
// Front end: decodes the function code and queues ticks for the engine.
module i2cra_front
  import i2cra_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  input  logic     cmd_pop,
  output cmd_t     cmd,
  output logic     cmd_empty
);

  cmd_t cmd_in;

  always_comb begin
    cmd_in.start    = (in_data.func == FUNC_READ) || (in_data.func == FUNC_WRITE);
    cmd_in.is_read  = (in_data.func == FUNC_READ);
    cmd_in.dev_addr = in_data.dev_addr;
    cmd_in.reg_addr = in_data.reg_addr;
    cmd_in.wdata    = in_data.wdata;
    cmd_in.is_word  = in_data.is_word;
    cmd_in.sda_in   = in_data.sda_in;
  end

  i2cra_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (cmd),
    .empty (cmd_empty)
  );

endmodule

// File: rtl/i2cra_engine.sv
// Back end: bus sequencer, advances one tick per queued command.
module i2cra_engine
  import i2cra_pkg::*;
#(
  parameter int DELAY_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  cmd_t                 cmd,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  output out_item_t            res,
  output logic                 res_push,
  input  logic                 res_full
);

  localparam int TW = ((DELAY_BITS > CFG_W) ? DELAY_BITS : CFG_W) + 1;
  localparam logic [CFG_W-1:0] DMASK =
    (DELAY_BITS >= CFG_W) ? {CFG_W{1'b1}} : CFG_W'((1 << DELAY_BITS) - 1);

  logic [CFG_W-1:0]      half_r, setup_r;
  phase_t                phase_r, phase_nxt;
  logic [DELAY_BITS-1:0] tick_r, tick_nxt;
  logic [2:0]            bit_r, bit_nxt;
  logic [2:0]            bstep_r, bstep_nxt;
  logic [7:0]            shift_r, shift_nxt;
  held_t                 held_r, held_nxt;
  logic [15:0]           rv_r, rv_nxt;
  logic                  scl_r, scl_nxt;
  logic                  sda_r, sda_nxt;

  logic             step;
  logic             busy, done, nack;
  logic             line_scl, line_sda;
  logic [CFG_W-1:0] seg_raw;
  logic [TW-1:0]    seg_len;
  logic             load_wr, load_rd;
  logic [7:0]       wr_byte;

  assign step     = !cmd_empty && !res_full;
  assign cmd_pop  = step;
  assign res_push = step;

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    bstep_nxt = bstep_r;
    shift_nxt = shift_r;
    held_nxt  = held_r;
    rv_nxt    = rv_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    busy      = 1'b0;
    done      = 1'b0;
    nack      = 1'b0;
    load_wr   = 1'b0;
    load_rd   = 1'b0;
    wr_byte   = '0;
    seg_raw   = '0;
    seg_len   = '0;

    if (phase_r == PH_IDLE && cmd.start) begin
      held_nxt.is_read  = cmd.is_read;
      held_nxt.is_word  = cmd.is_word;
      held_nxt.dev_addr = cmd.dev_addr;
      held_nxt.reg_addr = cmd.reg_addr;
      held_nxt.wdata    = cmd.wdata;
      bstep_nxt = STEP_DEV;
      phase_nxt = PH_START_A;
      tick_nxt  = '0;
      scl_nxt   = 1'b1;
      sda_nxt   = 1'b0;
    end

    line_scl = scl_nxt;
    line_sda = sda_nxt;

    if (phase_nxt != PH_IDLE) begin
      busy = 1'b1;
      if (phase_nxt inside {PH_START_B, PH_W_SET, PH_RA_SET, PH_STOP_B}) begin
        seg_raw = setup_r;
      end else begin
        seg_raw = half_r;
      end
      seg_len = (seg_raw == '0) ? TW'(1) : TW'(seg_raw);
      if (TW'(tick_nxt) + TW'(1) < seg_len) begin
        tick_nxt = tick_nxt + 1'b1;
      end else begin
        tick_nxt = '0;
        case (phase_nxt)
          PH_START_A: begin
            phase_nxt = PH_START_B;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
          end
          PH_START_B: begin
            load_wr = 1'b1;
            wr_byte = (bstep_nxt == STEP_DEV) ? {held_nxt.dev_addr[7:1], 1'b0}
                                              : {held_nxt.dev_addr[7:1], 1'b1};
          end
          PH_W_LOW: begin
            phase_nxt = PH_W_SET;
            scl_nxt   = 1'b0;
            sda_nxt   = ~shift_nxt[bit_nxt];
          end
          PH_W_SET: begin
            phase_nxt = PH_W_HIGH;
            scl_nxt   = 1'b1;
          end
          PH_W_HIGH: begin
            scl_nxt = 1'b0;
            if (bit_nxt == '0) begin
              phase_nxt = PH_WA_LOW;
            end else begin
              bit_nxt   = bit_nxt - 1'b1;
              phase_nxt = PH_W_LOW;
            end
          end
          PH_WA_LOW: begin
            phase_nxt = PH_WA_REL;
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b0;
          end
          PH_WA_REL: begin
            phase_nxt = PH_WA_HIGH;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b0;
          end
          PH_WA_HIGH: begin
            if (cmd.sda_in) begin
              done      = 1'b1;
              nack      = 1'b1;
              phase_nxt = PH_IDLE;
            end else if (bstep_nxt == STEP_DEV) begin
              bstep_nxt = STEP_REG;
              load_wr   = 1'b1;
              wr_byte   = held_nxt.reg_addr;
            end else if (held_nxt.is_read) begin
              if (bstep_nxt == STEP_REG) begin
                bstep_nxt = STEP_LO;
                phase_nxt = PH_START_A;
                scl_nxt   = 1'b1;
                sda_nxt   = 1'b0;
              end else begin
                bstep_nxt = STEP_HI;
                load_rd   = 1'b1;
              end
            end else if (bstep_nxt == STEP_REG) begin
              bstep_nxt = STEP_LO;
              load_wr   = 1'b1;
              wr_byte   = held_nxt.wdata[7:0];
            end else if (bstep_nxt == STEP_LO && held_nxt.is_word) begin
              bstep_nxt = STEP_HI;
              load_wr   = 1'b1;
              wr_byte   = held_nxt.wdata[15:8];
            end else begin
              phase_nxt = PH_STOP_A;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
            end
          end
          PH_R_LOW: begin
            phase_nxt = PH_R_HIGH;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b0;
          end
          PH_R_HIGH: begin
            shift_nxt = {shift_nxt[6:0], cmd.sda_in};
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b0;
            if (bit_nxt == '0) begin
              phase_nxt = PH_RA_LOW;
            end else begin
              bit_nxt   = bit_nxt - 1'b1;
              phase_nxt = PH_R_LOW;
            end
          end
          PH_RA_LOW: begin
            phase_nxt = PH_RA_SET;
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b1;
          end
          PH_RA_SET: begin
            phase_nxt = PH_RA_HIGH;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
          end
          PH_RA_HIGH: begin
            if (bstep_nxt == STEP_HI) begin
              rv_nxt = {8'h00, shift_nxt};
            end else begin
              rv_nxt = {shift_nxt, rv_nxt[7:0]};
            end
            if (bstep_nxt == STEP_HI && held_nxt.is_word) begin
              bstep_nxt = STEP_RD_HI;
              load_rd   = 1'b1;
            end else begin
              phase_nxt = PH_STOP_A;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
            end
          end
          PH_STOP_A: begin
            phase_nxt = PH_STOP_B;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b0;
          end
          default: begin
            done      = 1'b1;
            phase_nxt = PH_IDLE;
          end
        endcase

        if (load_wr) begin
          shift_nxt = wr_byte;
          bit_nxt   = 3'd7;
          phase_nxt = PH_W_LOW;
          scl_nxt   = 1'b0;
        end
        if (load_rd) begin
          shift_nxt = '0;
          bit_nxt   = 3'd7;
          phase_nxt = PH_R_LOW;
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b0;
        end
      end
    end

    res.scl_level    = line_scl;
    res.sda_pull_low = line_sda;
    res.busy_res     = busy;
    res.done_res     = done;
    res.nack_error   = nack;
    res.rdata        = rv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= HALF_PERIOD_RST;
      setup_r <= SETUP_RST;
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      bstep_r <= STEP_DEV;
      shift_r <= '0;
      held_r  <= '0;
      rv_r    <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_HALF_PERIOD: half_r  <= cfg_wdata & DMASK;
          REG_SETUP:       setup_r <= cfg_wdata & DMASK;
          default: ;
        endcase
      end
      if (step) begin
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        bit_r   <= bit_nxt;
        bstep_r <= bstep_nxt;
        shift_r <= shift_nxt;
        held_r  <= held_nxt;
        rv_r    <= rv_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
      end
    end
  end

endmodule

// File: rtl/i2c_master_register_access_unit.sv
// Top level of the I2C register access unit: front queue, engine, result queue.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------
//   in_      | in_push / in_full  | in_data  (func, addrs, wdata, sda_in)
//   out_     | out_pop / out_empty| out_data (bus levels, status, rdata)
//   cfg_     | cfg_we             | cfg_idx, cfg_wdata
//
// One bus tick per clock sustained while the engine does not stall; a result
// reaches the out_ ports through a registered path and is popped from there
// (command queue, then engine step into result queue).
// Synchronous reset; timing registers come up at 6 and 5 ticks.
// in_full rises only when the command queue holds CMD_DEPTH ticks; the engine
// stalls only when the command queue is empty or the result queue is full.
`include "i2c_master_register_access_unit_macros.svh"

module i2c_master_register_access_unit
  import i2cra_pkg::*;
#(
  parameter int DELAY_BITS = 10,
  parameter int CMD_DEPTH  = 2,
  parameter int RES_DEPTH  = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  in_item_t             in_data,
  input  logic                 out_pop,
  output logic                 out_empty,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cmd_t      cmd;
  logic      cmd_empty;
  logic      cmd_pop;
  out_item_t eng_res;
  logic      eng_push;
  logic      res_full;

  i2cra_front #(
    .DEPTH (CMD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  i2cra_engine #(
    .DELAY_BITS (DELAY_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (eng_res),
    .res_push  (eng_push),
    .res_full  (res_full)
  );

  i2cra_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (eng_push),
    .din   (eng_res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_data),
    .empty (out_empty)
  );

  `I2CRA_ASSERT_IMP(a_res_no_overflow, eng_push, !res_full, "result queue overflow")
  `I2CRA_ASSERT_IMP(a_done_busy, eng_push && eng_res.done_res, eng_res.busy_res, "done without busy")
  `I2CRA_ASSERT_IMP(a_nack_done, eng_push && eng_res.nack_error, eng_res.done_res, "nack without done")
  `I2CRA_ASSERT_NXT(a_cmd_queued, in_push && !in_full, !cmd_empty, "accepted tick not queued")

endmodule
